// ----- design/radio_link_connection_fsm_core_defines.svh -----
// assertion macros for the radio link connection checker
// depends on nothing; the including module provides clk and arst_n
`ifndef RADIO_LINK_CONNECTION_FSM_CORE_DEFINES_SVH
`define RADIO_LINK_CONNECTION_FSM_CORE_DEFINES_SVH

// same-cycle implication, reset aware
`define RLC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rlc check failed");

// next-cycle implication, reset aware
`define RLC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rlc check failed");

`endif

// ----- design/rlc_pkg.sv -----
// types and constants shared by the radio link connection blocks
// no dependencies
package rlc_pkg;

	// operation codes on the input side
	localparam logic [2:0] OP_START_CONNECT = 3'd0;
	localparam logic [2:0] OP_RELEASE       = 3'd1;
	localparam logic [2:0] OP_SUSPEND_REQ   = 3'd2;
	localparam logic [2:0] OP_FORCE_IDLE    = 3'd3;
	localparam logic [2:0] OP_START_RESUME  = 3'd4;
	localparam logic [2:0] OP_RESTORE       = 3'd5;
	localparam logic [2:0] OP_RX_MESSAGE    = 3'd6;

	// received message types
	localparam logic [2:0] RX_SETUP       = 3'd0;
	localparam logic [2:0] RX_RELEASE     = 3'd1;
	localparam logic [2:0] RX_RESUME_OK   = 3'd2;
	localparam logic [2:0] RX_RESUME_FAIL = 3'd3;

	// classified commands handed from front to back
	localparam logic [3:0] CMD_NOP         = 4'd0;
	localparam logic [3:0] CMD_CONNECT     = 4'd1;
	localparam logic [3:0] CMD_RELEASE     = 4'd2;
	localparam logic [3:0] CMD_SUSPEND_REQ = 4'd3;
	localparam logic [3:0] CMD_FORCE_IDLE  = 4'd4;
	localparam logic [3:0] CMD_RESUME      = 4'd5;
	localparam logic [3:0] CMD_RESTORE     = 4'd6;
	localparam logic [3:0] CMD_RX_SETUP    = 4'd7;
	localparam logic [3:0] CMD_RX_RELEASE  = 4'd8;
	localparam logic [3:0] CMD_RX_RES_OK   = 4'd9;
	localparam logic [3:0] CMD_RX_RES_FAIL = 4'd10;

	// link states
	localparam logic [1:0] ST_IDLE       = 2'd0;
	localparam logic [1:0] ST_CONNECTING = 2'd1;
	localparam logic [1:0] ST_CONNECTED  = 2'd2;
	localparam logic [1:0] ST_INACTIVE   = 2'd3;

	// message kinds to send
	localparam logic [1:0] KIND_SETUP_REQ  = 2'd0;
	localparam logic [1:0] KIND_SETUP_DONE = 2'd1;
	localparam logic [1:0] KIND_RELEASE    = 2'd2;

	// resume notification codes
	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_OK   = 2'd1;
	localparam logic [1:0] RES_FAIL = 2'd2;

	localparam logic [7:0] SUSPEND_REQ_FLAGS = 8'h02;
	localparam logic [2:0] RX_LEN_ID         = 3'd2;
	localparam logic [2:0] RX_LEN_FULL       = 3'd7;

	// bus widths
	localparam int S_DATA_W = 96;
	localparam int M_DATA_W = 80;
	localparam int QUEUE_DEPTH = 2;

	// one classified item in the queue
	typedef struct packed {
		logic [3:0]  cmd;
		logic        long_id;    // id field present (or targeted connect)
		logic        suspend_ok; // full release with suspension bit set
		logic [15:0] id;
		logic [31:0] rsm_ident;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic        send_valid;
		logic [1:0]  send_kind;
		logic [1:0]  send_length;
		logic [15:0] send_id;
		logic [7:0]  send_flags;
		logic        suspend_event;
		logic [1:0]  resume_event;
		logic [31:0] event_value;
		logic        ignored;
		logic [1:0]  link_state;
		logic [15:0] current_id;
	} result_t;

endpackage

// ----- design/rlc_front.sv -----
// front part: decodes operation and received type into a queue command
// depends on rlc_pkg
module rlc_front (
	input  logic [2:0]                      operation,
	input  logic [rlc_pkg::S_DATA_W-1:0]    payload,
	output rlc_pkg::cmd_t                   cmd
);

	logic [15:0] cell_id;
	logic [15:0] restore_id;
	logic [2:0]  rx_type;
	logic [2:0]  rx_length;
	logic [15:0] rx_id;
	logic [7:0]  rx_flags;
	logic [31:0] rx_resume_id;

	// unpack the bus fields
	assign cell_id      = payload[15:0];
	assign restore_id   = payload[31:16];
	assign rx_type      = payload[34:32];
	assign rx_length    = payload[37:35];
	assign rx_id        = payload[53:38];
	assign rx_flags     = payload[61:54];
	assign rx_resume_id = payload[93:62];

	// classify the item and pick the id that goes with it
	always_comb begin
		cmd.cmd        = rlc_pkg::CMD_NOP;
		cmd.long_id    = (rx_length >= rlc_pkg::RX_LEN_ID);
		cmd.suspend_ok = (rx_length == rlc_pkg::RX_LEN_FULL) && rx_flags[0];
		cmd.id         = rx_id;
		cmd.rsm_ident  = rx_resume_id;
		case (operation)
			rlc_pkg::OP_START_CONNECT: begin
				cmd.cmd     = rlc_pkg::CMD_CONNECT;
				cmd.long_id = (cell_id != 16'd0);
				cmd.id      = cell_id;
			end
			rlc_pkg::OP_RELEASE:      cmd.cmd = rlc_pkg::CMD_RELEASE;
			rlc_pkg::OP_SUSPEND_REQ:  cmd.cmd = rlc_pkg::CMD_SUSPEND_REQ;
			rlc_pkg::OP_FORCE_IDLE:   cmd.cmd = rlc_pkg::CMD_FORCE_IDLE;
			rlc_pkg::OP_START_RESUME: cmd.cmd = rlc_pkg::CMD_RESUME;
			rlc_pkg::OP_RESTORE: begin
				cmd.cmd = rlc_pkg::CMD_RESTORE;
				cmd.id  = restore_id;
			end
			rlc_pkg::OP_RX_MESSAGE: begin
				case (rx_type)
					rlc_pkg::RX_SETUP:       cmd.cmd = rlc_pkg::CMD_RX_SETUP;
					rlc_pkg::RX_RELEASE:     cmd.cmd = rlc_pkg::CMD_RX_RELEASE;
					rlc_pkg::RX_RESUME_OK:   cmd.cmd = rlc_pkg::CMD_RX_RES_OK;
					rlc_pkg::RX_RESUME_FAIL: cmd.cmd = rlc_pkg::CMD_RX_RES_FAIL;
					default:                 cmd.cmd = rlc_pkg::CMD_NOP;
				endcase
			end
			default: cmd.cmd = rlc_pkg::CMD_NOP;
		endcase
	end

endmodule

// ----- design/rlc_queue.sv -----
// two-entry command queue between front and back
// depends on rlc_pkg
module rlc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rlc_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output rlc_pkg::cmd_t  pop_cmd
);

	localparam int PtrW = $clog2(rlc_pkg::QUEUE_DEPTH);
	localparam int CntW = $clog2(rlc_pkg::QUEUE_DEPTH + 1);

	rlc_pkg::cmd_t   mem_q [rlc_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(rlc_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- design/rlc_back.sv -----
// back part: link state update and registered result
// depends on rlc_pkg
module rlc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  rlc_pkg::cmd_t   cmd,
	output logic            cmd_pop,
	output logic            res_valid,
	input  logic            res_ready,
	output rlc_pkg::result_t res
);

	logic [1:0]  state_q;
	logic [15:0] assigned_id_q;
	logic [31:0] resume_identity_q;
	logic        res_valid_q;
	rlc_pkg::result_t res_q;

	logic [1:0]  state_d;
	logic [15:0] assigned_id_d;
	logic [31:0] resume_identity_d;
	logic [15:0] resume_new_id;
	rlc_pkg::result_t res_d;

	assign cmd_pop   = cmd_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign resume_new_id = cmd.long_id ? cmd.id : assigned_id_q;

	// next state and result for the command at the queue head
	always_comb begin
		state_d           = state_q;
		assigned_id_d     = assigned_id_q;
		resume_identity_d = resume_identity_q;
		res_d             = '0;
		res_d.ignored     = 1'b1;
		case (cmd.cmd)
			rlc_pkg::CMD_CONNECT: begin
				if (state_q == rlc_pkg::ST_IDLE) begin
					res_d.ignored     = 1'b0;
					res_d.send_valid  = 1'b1;
					res_d.send_kind   = rlc_pkg::KIND_SETUP_REQ;
					res_d.send_length = cmd.long_id ? 2'd2 : 2'd1;
					res_d.send_id     = cmd.id;
					state_d           = rlc_pkg::ST_CONNECTING;
				end
			end
			rlc_pkg::CMD_RELEASE: begin
				if (state_q == rlc_pkg::ST_CONNECTED) begin
					res_d.ignored     = 1'b0;
					res_d.send_valid  = 1'b1;
					res_d.send_kind   = rlc_pkg::KIND_RELEASE;
					res_d.send_length = 2'd2;
					res_d.send_id     = assigned_id_q;
					state_d           = rlc_pkg::ST_IDLE;
					assigned_id_d     = '0;
				end
			end
			rlc_pkg::CMD_SUSPEND_REQ: begin
				if (state_q == rlc_pkg::ST_CONNECTED) begin
					res_d.ignored     = 1'b0;
					res_d.send_valid  = 1'b1;
					res_d.send_kind   = rlc_pkg::KIND_RELEASE;
					res_d.send_length = 2'd3;
					res_d.send_id     = assigned_id_q;
					res_d.send_flags  = rlc_pkg::SUSPEND_REQ_FLAGS;
				end
			end
			rlc_pkg::CMD_FORCE_IDLE: begin
				if (state_q != rlc_pkg::ST_IDLE) begin
					res_d.ignored     = 1'b0;
					state_d           = rlc_pkg::ST_IDLE;
					assigned_id_d     = '0;
					resume_identity_d = '0;
				end
			end
			rlc_pkg::CMD_RESUME: begin
				if (state_q == rlc_pkg::ST_INACTIVE) begin
					res_d.ignored = 1'b0;
					state_d       = rlc_pkg::ST_CONNECTING;
				end
			end
			rlc_pkg::CMD_RESTORE: begin
				res_d.ignored = 1'b0;
				state_d       = rlc_pkg::ST_CONNECTED;
				assigned_id_d = cmd.id;
			end
			rlc_pkg::CMD_RX_SETUP: begin
				if (state_q == rlc_pkg::ST_CONNECTING) begin
					res_d.ignored     = 1'b0;
					res_d.send_valid  = 1'b1;
					res_d.send_kind   = rlc_pkg::KIND_SETUP_DONE;
					res_d.send_length = 2'd2;
					res_d.send_id     = resume_new_id;
					assigned_id_d     = resume_new_id;
					state_d           = rlc_pkg::ST_CONNECTED;
				end
			end
			rlc_pkg::CMD_RX_RELEASE: begin
				res_d.ignored = 1'b0;
				if (cmd.suspend_ok && state_q == rlc_pkg::ST_CONNECTED) begin
					// suspension keeps the id for a later resume
					res_d.suspend_event = 1'b1;
					res_d.event_value   = cmd.rsm_ident;
					resume_identity_d   = cmd.rsm_ident;
					state_d             = rlc_pkg::ST_INACTIVE;
				end else begin
					assigned_id_d = '0;
					state_d       = rlc_pkg::ST_IDLE;
				end
			end
			rlc_pkg::CMD_RX_RES_OK: begin
				if (state_q == rlc_pkg::ST_CONNECTING && resume_identity_q != '0) begin
					res_d.ignored      = 1'b0;
					res_d.resume_event = rlc_pkg::RES_OK;
					res_d.event_value  = {16'd0, resume_new_id};
					assigned_id_d      = resume_new_id;
					resume_identity_d  = '0;
					state_d            = rlc_pkg::ST_CONNECTED;
				end
			end
			rlc_pkg::CMD_RX_RES_FAIL: begin
				if (state_q == rlc_pkg::ST_CONNECTING) begin
					res_d.ignored      = 1'b0;
					res_d.resume_event = rlc_pkg::RES_FAIL;
					assigned_id_d      = '0;
					resume_identity_d  = '0;
					state_d            = rlc_pkg::ST_IDLE;
				end
			end
			default: res_d.ignored = 1'b1;
		endcase
		res_d.link_state = state_d;
		res_d.current_id = assigned_id_d;
	end

	// link state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= rlc_pkg::ST_IDLE;
			assigned_id_q     <= '0;
			resume_identity_q <= '0;
			res_valid_q       <= 1'b0;
		end else begin
			if (cmd_pop) begin
				state_q           <= state_d;
				assigned_id_q     <= assigned_id_d;
				resume_identity_q <= resume_identity_d;
				res_valid_q       <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- design/radio_link_connection_fsm_core.sv -----
// Radio link connection control, user side: idle, connecting, connected and
// inactive states driven by local operations and decoded received messages.
// One item is accepted per cycle while s_tready is high, and every item gives
// exactly one result. An accepted item waits at the head of the two-entry
// command queue, then moves to the output register, which offers its result
// on m_tvalid. The back part takes one item per cycle from the queue while the
// output register is free or its result is taken; a stalled receiver fills
// the queue after two more items and then holds s_tready low until the result
// is taken.
// Depends on rlc_pkg, rlc_front, rlc_queue and rlc_back.
module radio_link_connection_fsm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell_id, restore_id, rx_type, rx_length, rx_id, rx_flags, rx_resume_id
	input  logic [rlc_pkg::S_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [2:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// send_length, send_id, send_flags, suspend_event, resume_event,
	// event_value, ignored, link_state, current_id
	output logic [rlc_pkg::M_DATA_W-1:0]  m_tdata,
	// send_valid, send_kind
	output logic [2:0]                    m_tuser
);

	rlc_pkg::cmd_t    front_cmd;
	rlc_pkg::cmd_t    head_cmd;
	rlc_pkg::result_t res;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;
	logic             q_push;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// classify incoming items
	rlc_front u_front (
		.operation (s_tuser),
		.payload   (s_tdata),
		.cmd       (front_cmd)
	);

	// decouple front from back
	rlc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_cmd   (head_cmd)
	);

	// execute commands
	rlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result onto the output bus
	assign m_tuser = {res.send_kind, res.send_valid};
	assign m_tdata = {res.current_id, res.link_state, res.ignored, res.event_value,
		res.resume_event, res.suspend_event, res.send_flags, res.send_id,
		res.send_length};

endmodule

// ----- design/rlc_checker.sv -----
// port-level checks for the radio link connection block, with its bind
// depends on radio_link_connection_fsm_core_defines.svh
`include "radio_link_connection_fsm_core_defines.svh"

module rlc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result holds
	`RLC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a rejected item sends nothing and reports no event
	`RLC_ASSERT_NOW(a_ignored_quiet, m_tvalid && m_tdata[61], m_tuser == 3'd0 && m_tdata[60:26] == 35'd0)

	// no message means all send fields are clear
	`RLC_ASSERT_NOW(a_no_send_clear, m_tvalid && !m_tuser[0], m_tuser[2:1] == 2'd0 && m_tdata[25:0] == 26'd0)

	// idle link never carries an id
	`RLC_ASSERT_NOW(a_idle_no_id, m_tvalid && m_tdata[63:62] == 2'd0, m_tdata[79:64] == 16'd0)

	// a suspension always leaves the link inactive
	`RLC_ASSERT_NOW(a_suspend_inactive, m_tvalid && m_tdata[26], m_tdata[63:62] == 2'd3)

endmodule

bind radio_link_connection_fsm_core rlc_checker u_rlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- bench/radio_link_connection_fsm_core_test.sv -----
// self-checking bench for the radio link connection control core
// depends on rlc_pkg and radio_link_connection_fsm_core; drives items, predicts and compares
module radio_link_connection_fsm_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rlc_pkg::*;

	// codes the package leaves unnamed
	localparam logic [2:0] OP_UNDEFINED = 3'd7;
	localparam logic [2:0] RX_OTHER     = 3'd4;
	localparam logic [2:0] RX_UNDEFINED = 3'd7;

	localparam int RANDOM_ITEMS = 1825;
	localparam int HOLD_CYCLES  = 60;

	// one input item, fields as the block sees them
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] target_cell;
		logic [15:0] rst_id;
		logic [2:0]  rx_type;
		logic [2:0]  rx_len;
		logic [15:0] rx_id;
		logic [7:0]  rx_flags;
		logic [31:0] rx_res;
	} link_item_t;

	// one line of the directed script; fixed rows carry their own result
	typedef struct packed {
		link_item_t item;
		logic       fixed;
		result_t    want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [2:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic [2:0]           m_tuser;

	// shadow copy of the link state
	logic [1:0]  link_st;
	logic [15:0] radio_id;
	logic [15:0] parked_id;
	logic [31:0] resume_ident;

	result_t     pending_results[$];
	script_row_t script[$];
	int          mismatches;
	int          items_taken;
	int          burst_left;

	radio_link_connection_fsm_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want_v);
		mismatches++;
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want_v);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want_v);
		if (got !== want_v)
			report_mismatch(what, got, want_v);
	endtask

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand32();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// received message handling; returns 1 when it took effect
	function automatic logic link_rx(input link_item_t it, inout result_t r);
		logic [15:0] nid;
		case (it.rx_type)
			RX_SETUP: begin
				if (link_st != ST_CONNECTING)
					return 1'b0;
				if (it.rx_len >= RX_LEN_ID)
					radio_id = it.rx_id;
				link_st = ST_CONNECTED;
				r.send_valid = 1'b1;
				r.send_kind = KIND_SETUP_DONE;
				r.send_length = 2'd2;
				r.send_id = radio_id;
				return 1'b1;
			end
			RX_RELEASE: begin
				// suspension only for a full payload with the bit set while connected
				if (it.rx_len == RX_LEN_FULL && it.rx_flags[0] && link_st == ST_CONNECTED) begin
					parked_id = radio_id;
					resume_ident = it.rx_res;
					link_st = ST_INACTIVE;
					r.suspend_event = 1'b1;
					r.event_value = it.rx_res;
				end else begin
					radio_id = '0;
					link_st = ST_IDLE;
				end
				return 1'b1;
			end
			RX_RESUME_OK: begin
				if (link_st != ST_CONNECTING || resume_ident == 0)
					return 1'b0;
				nid = (it.rx_len >= RX_LEN_ID) ? it.rx_id : radio_id;
				radio_id = nid;
				parked_id = '0;
				resume_ident = '0;
				link_st = ST_CONNECTED;
				r.resume_event = RES_OK;
				r.event_value = {16'h0, nid};
				return 1'b1;
			end
			RX_RESUME_FAIL: begin
				if (link_st != ST_CONNECTING)
					return 1'b0;
				radio_id = '0;
				parked_id = '0;
				resume_ident = '0;
				link_st = ST_IDLE;
				r.resume_event = RES_FAIL;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// next result of the link controller; updates the shadow state
	function automatic result_t link_next(input link_item_t it);
		result_t r;
		logic    took;
		r = '0;
		took = 1'b0;
		case (it.op)
			OP_START_CONNECT: begin
				if (link_st == ST_IDLE) begin
					r.send_valid = 1'b1;
					r.send_kind = KIND_SETUP_REQ;
					r.send_length = (it.target_cell != 0) ? 2'd2 : 2'd1;
					r.send_id = it.target_cell;
					link_st = ST_CONNECTING;
					took = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (link_st == ST_CONNECTED) begin
					r.send_valid = 1'b1;
					r.send_kind = KIND_RELEASE;
					r.send_length = 2'd2;
					r.send_id = radio_id;
					link_st = ST_IDLE;
					radio_id = '0;
					took = 1'b1;
				end
			end
			OP_SUSPEND_REQ: begin
				if (link_st == ST_CONNECTED) begin
					r.send_valid = 1'b1;
					r.send_kind = KIND_RELEASE;
					r.send_length = 2'd3;
					r.send_id = radio_id;
					r.send_flags = SUSPEND_REQ_FLAGS;
					took = 1'b1;
				end
			end
			OP_FORCE_IDLE: begin
				if (link_st != ST_IDLE) begin
					radio_id = '0;
					parked_id = '0;
					resume_ident = '0;
					link_st = ST_IDLE;
					took = 1'b1;
				end
			end
			OP_START_RESUME: begin
				if (link_st == ST_INACTIVE) begin
					link_st = ST_CONNECTING;
					took = 1'b1;
				end
			end
			OP_RESTORE: begin
				radio_id = it.rst_id;
				link_st = ST_CONNECTED;
				took = 1'b1;
			end
			OP_RX_MESSAGE: took = link_rx(it, r);
			default: took = 1'b0;
		endcase
		r.ignored = ~took;
		r.link_state = link_st;
		r.current_id = radio_id;
		return r;
	endfunction

	// random item, mostly steered toward what advances the current state
	function automatic link_item_t pick_item();
		link_item_t it;
		int         r;
		it.op = 3'($urandom_range(0, 7));
		it.target_cell = rand16();
		it.rst_id = rand16();
		it.rx_type = 3'($urandom_range(0, 7));
		it.rx_len = 3'($urandom_range(0, 7));
		it.rx_id = rand16();
		it.rx_flags = 8'($urandom_range(0, 255));
		it.rx_res = rand32();
		r = $urandom_range(0, 99);
		if (r < 82) begin
			case (link_st)
				ST_IDLE: it.op = (r < 70) ? OP_START_CONNECT : OP_RESTORE;
				ST_CONNECTING: begin
					it.op = OP_RX_MESSAGE;
					if (r < 40)
						it.rx_type = RX_SETUP;
					else if (r < 62)
						it.rx_type = RX_RESUME_OK;
					else if (r < 74)
						it.rx_type = RX_RESUME_FAIL;
					else
						it.op = OP_FORCE_IDLE;
				end
				ST_CONNECTED: begin
					if (r < 15) begin
						it.op = OP_RELEASE;
					end else if (r < 35) begin
						it.op = OP_SUSPEND_REQ;
					end else if (r < 70) begin
						it.op = OP_RX_MESSAGE;
						it.rx_type = RX_RELEASE;
						it.rx_len = RX_LEN_FULL;
						it.rx_flags[0] = 1'b1;
					end else if (r < 76) begin
						it.op = OP_RX_MESSAGE;
						it.rx_type = RX_RELEASE;
					end else begin
						it.op = OP_FORCE_IDLE;
					end
				end
				default: begin
					if (r < 68)
						it.op = OP_START_RESUME;
					else if (r < 75)
						it.op = OP_FORCE_IDLE;
					else
						it.op = OP_RESTORE;
				end
			endcase
		end
		return it;
	endfunction

	// offer one item in bursts with random gaps, then log what it should give
	task automatic drive_item(input link_item_t it, input logic fixed, input result_t want);
		int      gap;
		result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {2'b00, it.rx_res, it.rx_flags, it.rx_id, it.rx_len, it.rx_type,
			it.rst_id, it.target_cell};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = link_next(it);
		pending_results.push_back(fixed ? want : predicted);
		items_taken++;
	endtask

	// receiver: rotating stall patterns plus two long hold-offs
	initial begin : sink
		int cyc;
		int hold_left;
		int holds_done;
		cyc = 0;
		hold_left = 0;
		holds_done = 0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if ((holds_done == 0 && items_taken >= 300) ||
					(holds_done == 1 && items_taken >= 1200)) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				case ((cyc / 150) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= (cyc % 4 != 0);
					default: m_tready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		result_t seen;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.send_valid = m_tuser[0];
			seen.send_kind = m_tuser[2:1];
			seen.send_length = m_tdata[1:0];
			seen.send_id = m_tdata[17:2];
			seen.send_flags = m_tdata[25:18];
			seen.suspend_event = m_tdata[26];
			seen.resume_event = m_tdata[28:27];
			seen.event_value = m_tdata[60:29];
			seen.ignored = m_tdata[61];
			seen.link_state = m_tdata[63:62];
			seen.current_id = m_tdata[79:64];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result item", 32'(m_tdata), 32'h0);
			end else begin
				want = pending_results.pop_front();
				check_field("send_valid", 32'(seen.send_valid), 32'(want.send_valid));
				check_field("send_kind", 32'(seen.send_kind), 32'(want.send_kind));
				check_field("send_length", 32'(seen.send_length), 32'(want.send_length));
				check_field("send_id", 32'(seen.send_id), 32'(want.send_id));
				check_field("send_flags", 32'(seen.send_flags), 32'(want.send_flags));
				check_field("suspend_event", 32'(seen.suspend_event),
					32'(want.suspend_event));
				check_field("resume_event", 32'(seen.resume_event), 32'(want.resume_event));
				check_field("event_value", seen.event_value, want.event_value);
				check_field("ignored", 32'(seen.ignored), 32'(want.ignored));
				check_field("link_state", 32'(seen.link_state), 32'(want.link_state));
				check_field("current_id", 32'(seen.current_id), 32'(want.current_id));
			end
		end
	end

	// reset, directed script, random items, drain
	initial begin : stimulus
		link_item_t it;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		link_st = ST_IDLE;
		radio_id = '0;
		parked_id = '0;
		resume_ident = '0;
		mismatches = 0;
		items_taken = 0;
		burst_left = 0;

		// item: op, cell, restore id, rx type, rx len, rx id, rx flags, rx resume id
		// result: send valid/kind/length/id/flags, suspend, resume, value, ignored,
		// state, id
		script.push_back(script_row_t'{
			link_item_t'{OP_START_CONNECT, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b1, result_t'{1'b1, KIND_SETUP_REQ, 2'd1, 16'h0, 8'h0, 1'b0, RES_NONE, 32'h0,
			1'b0, ST_CONNECTING, 16'h0}});
		// short setup keeps the current id
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_SETUP, 3'd1, 16'h5A5A, 8'h0, 32'h0},
			1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_SUSPEND_REQ, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RELEASE, 3'd7, 16'h0, 8'h01,
			32'hFFFF_FFFF}, 1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b1,
			RES_NONE, 32'hFFFF_FFFF, 1'b0, ST_INACTIVE, 16'h0}});
		script.push_back(script_row_t'{
			link_item_t'{OP_RELEASE, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b0, RES_NONE, 32'h0,
			1'b1, ST_INACTIVE, 16'h0}});
		script.push_back(script_row_t'{
			link_item_t'{OP_START_RESUME, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b0, result_t'('0)});
		// short resume ok keeps the current id
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RESUME_OK, 3'd1, 16'h1111, 8'h0,
			32'h0}, 1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RESTORE, 16'h0, 16'hFFFF, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b0, RES_NONE, 32'h0,
			1'b0, ST_CONNECTED, 16'hFFFF}});
		script.push_back(script_row_t'{
			link_item_t'{OP_RELEASE, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b1, result_t'{1'b1, KIND_RELEASE, 2'd2, 16'hFFFF, 8'h0, 1'b0, RES_NONE, 32'h0,
			1'b0, ST_IDLE, 16'h0}});
		// force idle while idle does nothing
		script.push_back(script_row_t'{
			link_item_t'{OP_FORCE_IDLE, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b0, RES_NONE, 32'h0,
			1'b1, ST_IDLE, 16'h0}});
		script.push_back(script_row_t'{
			link_item_t'{OP_START_CONNECT, 16'hFFFF, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0,
			32'h0}, 1'b1, result_t'{1'b1, KIND_SETUP_REQ, 2'd2, 16'hFFFF, 8'h0, 1'b0,
			RES_NONE, 32'h0, 1'b0, ST_CONNECTING, 16'h0}});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_SETUP, 3'd7, 16'hFFFF, 8'hFF,
			32'hFFFF_FFFF}, 1'b0, result_t'('0)});
		// release one byte short of suspension, then release while idle
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RELEASE, 3'd6, 16'h0, 8'h01, 32'h0},
			1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RELEASE, 3'd7, 16'h0, 8'hFF,
			32'h1234_5678}, 1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RESTORE, 16'h0, 16'h1234, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b0, result_t'('0)});
		// full release without the suspension bit
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RELEASE, 3'd7, 16'h0, 8'hFE,
			32'hFFFF_FFFF}, 1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RESTORE, 16'h0, 16'hABCD, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b0, result_t'('0)});
		// suspension with a zero resume identity blocks the later resume ok
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RELEASE, 3'd7, 16'h0, 8'h01, 32'h0},
			1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_START_RESUME, 16'h0, 16'h0, RX_SETUP, 3'd0, 16'h0, 8'h0, 32'h0},
			1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RESUME_OK, 3'd7, 16'h2222, 8'h0,
			32'h0}, 1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RESUME_FAIL, 3'd0, 16'h0, 8'h0,
			32'h0}, 1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b0, RES_FAIL,
			32'h0, 1'b0, ST_IDLE, 16'h0}});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_RESUME_FAIL, 3'd0, 16'h0, 8'h0,
			32'h0}, 1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b0, RES_NONE,
			32'h0, 1'b1, ST_IDLE, 16'h0}});
		// other and undefined received types, undefined operation
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_OTHER, 3'd7, 16'hFFFF, 8'hFF,
			32'hFFFF_FFFF}, 1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_RX_MESSAGE, 16'h0, 16'h0, RX_UNDEFINED, 3'd7, 16'hFFFF, 8'hFF,
			32'hFFFF_FFFF}, 1'b0, result_t'('0)});
		script.push_back(script_row_t'{
			link_item_t'{OP_UNDEFINED, 16'hFFFF, 16'hFFFF, RX_SETUP, 3'd7, 16'hFFFF, 8'hFF,
			32'hFFFF_FFFF}, 1'b1, result_t'{1'b0, KIND_SETUP_REQ, 2'd0, 16'h0, 8'h0, 1'b0,
			RES_NONE, 32'h0, 1'b1, ST_IDLE, 16'h0}});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			drive_item(script[i].item, script[i].fixed, script[i].want);
		repeat (RANDOM_ITEMS) begin
			it = pick_item();
			drive_item(it, 1'b0, result_t'('0));
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain, then keep watching to catch stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
